>>> design/rgb_breathing_led_controller_unit_defines.svh
// Assertion macros of the RGB breathing LED controller, used by its controller module.
`ifndef RGB_BREATHING_LED_CONTROLLER_UNIT_DEFINES_SVH
`define RGB_BREATHING_LED_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion that is switched off while reset is high.
`define RBL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define RBL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBL_ASSERT(lbl, clk, rst, prop, msg)
`define RBL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> design/rbl_pkg.sv
// Shared types, codes and constants of the RGB breathing LED controller.
package rbl_pkg;

   // Channel geometry.
   localparam int NUM_CH      = 3;
   localparam int LEVEL_BITS  = 8;
   localparam int SUM_BITS    = LEVEL_BITS + 2;
   localparam int PERIOD_BITS = 16;
   localparam int CFG_BITS    = NUM_CH * LEVEL_BITS;
   localparam int PER_BITS    = NUM_CH * PERIOD_BITS;
   localparam int CSR_DATA_BITS = PER_BITS;

   localparam logic [PERIOD_BITS-1:0] CNT_MAX = '1;

   // Register reset values.
   localparam logic [LEVEL_BITS-1:0]  UPPER_RST_FIELD  = 8'd255;
   localparam logic [LEVEL_BITS-1:0]  LOWER_RST_FIELD  = 8'd0;
   localparam logic [LEVEL_BITS-1:0]  SPEED_RST_FIELD  = 8'd1;
   localparam logic [PERIOD_BITS-1:0] PERIOD_RST_FIELD = 16'd100;

   typedef logic [1:0] ch_idx_type;
   localparam ch_idx_type CH_FIRST = 2'd0;
   localparam ch_idx_type CH_LAST  = 2'(NUM_CH - 1);

   // Configuration register indexes.
   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CSR_UPPER   = 2'd0;
   localparam csr_idx_type CSR_LOWER   = 2'd1;
   localparam csr_idx_type CSR_SPEED   = 2'd2;
   localparam csr_idx_type CSR_PERIODS = 2'd3;

   // Command codes of an input item.
   typedef enum logic [2:0] {
      ACT_TICK         = 3'd0,
      ACT_GET          = 3'd1,
      ACT_MANUAL_OFF   = 3'd2,
      ACT_START_AUTO   = 3'd3,
      ACT_SET_LEVELS   = 3'd4,
      ACT_POWER        = 3'd5,
      ACT_RESET_TIMERS = 3'd6,
      ACT_FADE         = 3'd7
   } action_type;

   // Channel direction.
   typedef enum logic [1:0] {
      DIR_ZERO = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_CHAN = 2'd1,
      S_DONE = 2'd2
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic       load;
      logic       step_en;
      ch_idx_type ch;
      logic       out_load;
   } ctrl_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic auto_mode;
   } ctrl_status_type;

endpackage

>>> design/rbl_step_unit.sv
// Shared channel step unit: turn-around at the bounds, step and clamp.
module rbl_step_unit
   import rbl_pkg::*;
(
   input  logic [LEVEL_BITS-1:0] level,
   input  dir_type               dir,
   input  logic [LEVEL_BITS-1:0] upper,
   input  logic [LEVEL_BITS-1:0] lower,
   input  logic [LEVEL_BITS-1:0] speed,
   input  logic                  fading,
   output logic [LEVEL_BITS-1:0] level_out,
   output dir_type               dir_out,
   output logic                  fade_end
);

   logic                  turn_up;
   logic                  turn_dn;
   logic [LEVEL_BITS-1:0] base;
   dir_type               dir_next;
   logic signed [SUM_BITS-1:0] base_s;
   logic signed [SUM_BITS-1:0] speed_s;
   logic signed [SUM_BITS-1:0] upper_s;
   logic signed [SUM_BITS-1:0] lower_s;
   logic signed [SUM_BITS-1:0] sum_s;
   logic signed [SUM_BITS-1:0] clip_hi_s;
   logic signed [SUM_BITS-1:0] clip_lo_s;

   // A channel turns around once it sits at or beyond the bound it heads for.
   assign turn_up  = (dir == DIR_UP) && (level >= upper);
   assign turn_dn  = !turn_up && (dir == DIR_DOWN) && (level <= lower);
   assign base     = turn_up ? upper : (turn_dn ? lower : level);
   assign fade_end = (turn_up || turn_dn) && fading;

   // Direction after a possible turn.
   always_comb begin
      unique case (dir)
         DIR_UP:   dir_next = turn_up ? DIR_DOWN : DIR_UP;
         DIR_DOWN: dir_next = turn_dn ? DIR_UP : DIR_DOWN;
         default:  dir_next = DIR_ZERO;
      endcase
   end

   assign dir_out = fade_end ? DIR_ZERO : dir_next;

   // Step in wide signed arithmetic, then clamp to upper first and lower second.
   assign base_s  = $signed({2'b00, base});
   assign speed_s = $signed({2'b00, speed});
   assign upper_s = $signed({2'b00, upper});
   assign lower_s = $signed({2'b00, lower});

   always_comb begin
      unique case (dir_next)
         DIR_UP:   sum_s = base_s + speed_s;
         DIR_DOWN: sum_s = base_s - speed_s;
         default:  sum_s = base_s;
      endcase
   end

   assign clip_hi_s = (sum_s > upper_s) ? upper_s : sum_s;
   assign clip_lo_s = (clip_hi_s < lower_s) ? lower_s : clip_hi_s;

   assign level_out = fade_end ? base : clip_lo_s[LEVEL_BITS-1:0];

endmodule

>>> design/rbl_controller.sv
// Controller state machine: sequences commands, channel steps and result transfers.
`include "rgb_breathing_led_controller_unit_defines.svh"

module rbl_controller
   import rbl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [2:0]      req_action,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type  state_ff;
   state_type  state_in;
   ch_idx_type ch_ff;
   ch_idx_type ch_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // State, channel index and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= CH_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      cmd.load     = 1'b0;
      cmd.step_en  = 1'b0;
      cmd.ch       = ch_ff;
      cmd.out_load = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               ch_in    = CH_FIRST;
               if (action_type'(req_action) == ACT_TICK) begin
                  state_in = S_CHAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_CHAN: begin
            // The mode is checked again before each channel.
            if (!status.auto_mode) begin
               state_in = S_DONE;
            end else begin
               cmd.step_en = 1'b1;
               if (ch_ff == CH_LAST) begin
                  state_in = S_DONE;
               end else begin
                  ch_in = ch_ff + 2'd1;
               end
            end
         end
         S_DONE: begin
            // The result enters the output register once it is free.
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `RBL_ASSERT(a_tick_starts_red, clock, reset, (req_valid && req_ready && (action_type'(req_action) == ACT_TICK)) |=> (state_ff == S_CHAN && ch_ff == CH_FIRST), "tick transfer did not start at the red channel")
   `RBL_ASSERT(a_cmd_goes_done, clock, reset, (req_valid && req_ready && (action_type'(req_action) != ACT_TICK)) |=> (state_ff == S_DONE), "command transfer did not go to result state")
   `RBL_ASSERT(a_step_ch_range, clock, reset, cmd.step_en |-> (cmd.ch <= CH_LAST), "step issued for a channel that does not exist")
   `RBL_ASSERT(a_load_shows_valid, clock, reset, cmd.out_load |=> rsp_valid_ff, "loaded result is not offered")
   `RBL_ASSERT_ALWAYS(a_no_overwrite, clock, (cmd.out_load && !reset) |-> out_free, "result overwritten before its transfer")

endmodule

>>> design/rbl_datapath.sv
// Datapath: configuration, channel state, shared step unit and output register.
module rbl_datapath
   import rbl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [1:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wr_data,
   input  logic [2:0]               req_action,
   input  logic [LEVEL_BITS-1:0]    req_red_value,
   input  logic [LEVEL_BITS-1:0]    req_green_value,
   input  logic [LEVEL_BITS-1:0]    req_blue_value,
   input  logic                     req_flag,
   input  ctrl_cmd_type             cmd,
   output ctrl_status_type          status,
   output logic [LEVEL_BITS-1:0]    rsp_level_red,
   output logic [LEVEL_BITS-1:0]    rsp_level_green,
   output logic [LEVEL_BITS-1:0]    rsp_level_blue,
   output logic                     rsp_lamp_on,
   output logic                     rsp_auto_mode,
   output logic                     rsp_fading_active
);

   // Configuration registers.
   logic [NUM_CH-1:0][LEVEL_BITS-1:0]  upper_ff, upper_in;
   logic [NUM_CH-1:0][LEVEL_BITS-1:0]  lower_ff, lower_in;
   logic [NUM_CH-1:0][LEVEL_BITS-1:0]  speed_ff, speed_in;
   logic [NUM_CH-1:0][PERIOD_BITS-1:0] period_ff, period_in;

   // Channel and mode state.
   logic [NUM_CH-1:0][LEVEL_BITS-1:0]  level_ff, level_in;
   dir_type [NUM_CH-1:0]               dir_ff, dir_in;
   logic [NUM_CH-1:0][PERIOD_BITS-1:0] elapsed_ff, elapsed_in;
   logic mode_ff, mode_in;
   logic power_ff, power_in;
   logic fading_ff, fading_in;

   // Output register.
   logic [LEVEL_BITS-1:0] out_red_ff, out_green_ff, out_blue_ff;
   logic out_power_ff, out_auto_ff, out_fading_ff;

   action_type            act;
   logic                  restart;
   logic                  expired;
   logic [LEVEL_BITS-1:0] step_level;
   dir_type               step_dir;
   logic                  step_fade_end;

   assign act              = action_type'(req_action);
   assign status.auto_mode = mode_ff;
   assign expired          = elapsed_ff[cmd.ch] >= period_ff[cmd.ch];

   // One step unit, shared by the three channels in turn.
   rbl_step_unit u_step (
      .level     (level_ff[cmd.ch]),
      .dir       (dir_ff[cmd.ch]),
      .upper     (upper_ff[cmd.ch]),
      .lower     (lower_ff[cmd.ch]),
      .speed     (speed_ff[cmd.ch]),
      .fading    (fading_ff),
      .level_out (step_level),
      .dir_out   (step_dir),
      .fade_end  (step_fade_end)
   );

   // Next values of configuration and state.
   always_comb begin
      upper_in   = upper_ff;
      lower_in   = lower_ff;
      speed_in   = speed_ff;
      period_in  = period_ff;
      level_in   = level_ff;
      dir_in     = dir_ff;
      elapsed_in = elapsed_ff;
      mode_in    = mode_ff;
      power_in   = power_ff;
      fading_in  = fading_ff;
      restart    = 1'b0;

      // Configuration writes; a period write restarts the counters.
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_UPPER:   upper_in = csr_wr_data[CFG_BITS-1:0];
            CSR_LOWER:   lower_in = csr_wr_data[CFG_BITS-1:0];
            CSR_SPEED:   speed_in = csr_wr_data[CFG_BITS-1:0];
            CSR_PERIODS: begin
               period_in = csr_wr_data[PER_BITS-1:0];
               restart   = 1'b1;
            end
            default: ;
         endcase
      end

      // Command of a transferred item.
      if (cmd.load) begin
         unique case (act)
            ACT_TICK: begin
               for (int i = 0; i < NUM_CH; i++) begin
                  if (elapsed_ff[i] != CNT_MAX) begin
                     elapsed_in[i] = elapsed_ff[i] + 1'b1;
                  end
               end
            end
            ACT_GET: ;
            ACT_MANUAL_OFF: begin
               mode_in  = 1'b0;
               power_in = 1'b0;
            end
            ACT_START_AUTO: begin
               level_in = {req_blue_value, req_green_value, req_red_value};
               mode_in  = 1'b1;
               restart  = 1'b1;
            end
            ACT_SET_LEVELS: begin
               level_in = {req_blue_value, req_green_value, req_red_value};
            end
            ACT_POWER: begin
               power_in = req_flag;
            end
            ACT_RESET_TIMERS: begin
               restart = 1'b1;
            end
            ACT_FADE: begin
               for (int i = 0; i < NUM_CH; i++) begin
                  dir_in[i] = req_flag ? DIR_UP : DIR_DOWN;
               end
               fading_in = 1'b1;
               mode_in   = 1'b1;
               restart   = 1'b1;
            end
            default: ;
         endcase
      end

      // Step of one expired channel; reaching a bound while fading ends the fade.
      if (cmd.step_en && mode_ff && expired) begin
         level_in[cmd.ch]   = step_level;
         dir_in[cmd.ch]     = step_dir;
         elapsed_in[cmd.ch] = '0;
         if (step_fade_end) begin
            mode_in   = 1'b0;
            fading_in = 1'b0;
         end
      end

      if (restart) begin
         elapsed_in = '0;
      end
   end

   // Configuration and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CH; i++) begin
            upper_ff[i]   <= UPPER_RST_FIELD;
            lower_ff[i]   <= LOWER_RST_FIELD;
            speed_ff[i]   <= SPEED_RST_FIELD;
            period_ff[i]  <= PERIOD_RST_FIELD;
            level_ff[i]   <= '0;
            dir_ff[i]     <= DIR_UP;
            elapsed_ff[i] <= '0;
         end
         mode_ff   <= 1'b0;
         power_ff  <= 1'b0;
         fading_ff <= 1'b0;
      end else begin
         upper_ff   <= upper_in;
         lower_ff   <= lower_in;
         speed_ff   <= speed_in;
         period_ff  <= period_in;
         level_ff   <= level_in;
         dir_ff     <= dir_in;
         elapsed_ff <= elapsed_in;
         mode_ff    <= mode_in;
         power_ff   <= power_in;
         fading_ff  <= fading_in;
      end
   end

   // Output register, loaded with the state after the item.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_red_ff    <= level_ff[0];
         out_green_ff  <= level_ff[1];
         out_blue_ff   <= level_ff[2];
         out_power_ff  <= power_ff;
         out_auto_ff   <= mode_ff;
         out_fading_ff <= fading_ff;
      end
   end

   assign rsp_level_red     = out_red_ff;
   assign rsp_level_green   = out_green_ff;
   assign rsp_level_blue    = out_blue_ff;
   assign rsp_lamp_on       = out_power_ff;
   assign rsp_auto_mode     = out_auto_ff;
   assign rsp_fading_active = out_fading_ff;

endmodule

>>> design/rgb_breathing_led_controller_unit.sv
// Top level of the RGB breathing LED controller: controller plus datapath.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/ready     action, red/green/blue value, flag
//   rsp      out        rsp_valid/ready     three levels, power, auto, fading
//   csr      in         csr_wr_en           csr_index, csr_wr_data
//
// A tick passes through the transfer, a step of each channel in turn in the
// shared step unit (red, green, blue), and the output register load; it ends
// early once the mode is manual. Every other command goes from the transfer straight to the output register load.
// Reset is synchronous and restores all registers but the output register to their reset values.
// A new item is taken while a result waits; it then holds in its last cycle
// until the output register is free.
module rgb_breathing_led_controller_unit
   import rbl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [1:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_action,
   input  logic [LEVEL_BITS-1:0]    req_red_value,
   input  logic [LEVEL_BITS-1:0]    req_green_value,
   input  logic [LEVEL_BITS-1:0]    req_blue_value,
   input  logic                     req_flag,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [LEVEL_BITS-1:0]    rsp_level_red,
   output logic [LEVEL_BITS-1:0]    rsp_level_green,
   output logic [LEVEL_BITS-1:0]    rsp_level_blue,
   output logic                     rsp_lamp_on,
   output logic                     rsp_auto_mode,
   output logic                     rsp_fading_active
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Sequencing of transfers and channel steps.
   rbl_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // State, configuration and arithmetic.
   rbl_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_action        (req_action),
      .req_red_value     (req_red_value),
      .req_green_value   (req_green_value),
      .req_blue_value    (req_blue_value),
      .req_flag          (req_flag),
      .cmd               (cmd),
      .status            (status),
      .rsp_level_red     (rsp_level_red),
      .rsp_level_green   (rsp_level_green),
      .rsp_level_blue    (rsp_level_blue),
      .rsp_lamp_on       (rsp_lamp_on),
      .rsp_auto_mode     (rsp_auto_mode),
      .rsp_fading_active (rsp_fading_active)
   );

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the RGB breathing LED controller unit.
module testbench
   import rbl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // One command item and one status word as the block sees them.
   typedef struct {
      action_type            action;
      logic [LEVEL_BITS-1:0] red;
      logic [LEVEL_BITS-1:0] green;
      logic [LEVEL_BITS-1:0] blue;
      logic                  flag;
   } led_cmd_type;

   typedef struct {
      logic [LEVEL_BITS-1:0] red;
      logic [LEVEL_BITS-1:0] green;
      logic [LEVEL_BITS-1:0] blue;
      logic                  lamp_on;
      logic                  auto_on;
      logic                  fade_on;
   } led_status_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [1:0]               csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [2:0]               req_action = '0;
   logic [LEVEL_BITS-1:0]    req_red_value = '0;
   logic [LEVEL_BITS-1:0]    req_green_value = '0;
   logic [LEVEL_BITS-1:0]    req_blue_value = '0;
   logic                     req_flag = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [LEVEL_BITS-1:0]    rsp_level_red;
   logic [LEVEL_BITS-1:0]    rsp_level_green;
   logic [LEVEL_BITS-1:0]    rsp_level_blue;
   logic                     rsp_lamp_on;
   logic                     rsp_auto_mode;
   logic                     rsp_fading_active;

   rgb_breathing_led_controller_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_red_value     (req_red_value),
      .req_green_value   (req_green_value),
      .req_blue_value    (req_blue_value),
      .req_flag          (req_flag),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_level_red     (rsp_level_red),
      .rsp_level_green   (rsp_level_green),
      .rsp_level_blue    (rsp_level_blue),
      .rsp_lamp_on       (rsp_lamp_on),
      .rsp_auto_mode     (rsp_auto_mode),
      .rsp_fading_active (rsp_fading_active)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the registers and of the channel state.
   logic [CFG_BITS-1:0]    upper_cfg;
   logic [CFG_BITS-1:0]    lower_cfg;
   logic [CFG_BITS-1:0]    speed_cfg;
   logic [PER_BITS-1:0]    period_cfg;
   logic [LEVEL_BITS-1:0]  level_now [NUM_CH];
   dir_type                dir_now [NUM_CH];
   logic [PERIOD_BITS-1:0] elapsed_cnt [NUM_CH];
   logic                   auto_on;
   logic                   lamp_on;
   logic                   fade_on;

   led_cmd_type    cmd_pending [$];
   led_status_type status_due [$];
   led_cmd_type    req_item;
   led_status_type want_word;

   int  send_hold = 0;
   int  stall_left = 0;
   bit  idle_on = 1'b1;
   int  fail_count = 0;
   int  cmds_sent = 0;
   int  ticks_sent = 0;
   int  words_checked = 0;
   int  settings_used = 0;

   function automatic void restart_timers();
      for (int c = 0; c < NUM_CH; c++) begin
         elapsed_cnt[c] = '0;
      end
   endfunction

   function automatic int dir_value(dir_type d);
      case (d)
         DIR_UP:   return 1;
         DIR_DOWN: return -1;
         default:  return 0;
      endcase
   endfunction

   // One update of a channel: turn around at a bound, then step and clamp.
   function automatic void step_channel(int ch);
      int up;
      int lo;
      int sp;
      int lv;
      int dv;
      bit turn;
      up = upper_cfg[LEVEL_BITS*ch +: LEVEL_BITS];
      lo = lower_cfg[LEVEL_BITS*ch +: LEVEL_BITS];
      sp = speed_cfg[LEVEL_BITS*ch +: LEVEL_BITS];
      lv = level_now[ch];
      dv = dir_value(dir_now[ch]);
      turn = 1'b0;
      if (lv >= up && dir_now[ch] == DIR_UP) begin
         lv = up;
         turn = 1'b1;
      end else if (lv <= lo && dir_now[ch] == DIR_DOWN) begin
         lv = lo;
         turn = 1'b1;
      end
      // A one-shot fade stops at the first bound it meets.
      if (turn && fade_on) begin
         level_now[ch] = lv[LEVEL_BITS-1:0];
         auto_on = 1'b0;
         dir_now[ch] = DIR_ZERO;
         fade_on = 1'b0;
         return;
      end
      if (turn) begin
         dir_now[ch] = (dir_now[ch] == DIR_UP) ? DIR_DOWN : DIR_UP;
         dv = -dv;
      end
      lv = lv + dv * sp;
      // Upper clamp first, so a lower bound above the upper one wins.
      if (lv > up) lv = up;
      if (lv < lo) lv = lo;
      level_now[ch] = lv[LEVEL_BITS-1:0];
   endfunction

   // Applies one command to the shadow state and returns the status it leaves.
   function automatic led_status_type apply_command(led_cmd_type cmd);
      led_status_type word;
      case (cmd.action)
         ACT_TICK: begin
            for (int c = 0; c < NUM_CH; c++) begin
               if (elapsed_cnt[c] < CNT_MAX) elapsed_cnt[c] = elapsed_cnt[c] + 1'b1;
            end
            for (int c = 0; c < NUM_CH; c++) begin
               if (!auto_on) break;
               if (elapsed_cnt[c] >= period_cfg[PERIOD_BITS*c +: PERIOD_BITS]) begin
                  step_channel(c);
                  elapsed_cnt[c] = '0;
               end
            end
         end
         ACT_GET: begin
         end
         ACT_MANUAL_OFF: begin
            auto_on = 1'b0;
            lamp_on = 1'b0;
         end
         ACT_START_AUTO: begin
            level_now[0] = cmd.red;
            level_now[1] = cmd.green;
            level_now[2] = cmd.blue;
            auto_on = 1'b1;
            restart_timers();
         end
         ACT_SET_LEVELS: begin
            level_now[0] = cmd.red;
            level_now[1] = cmd.green;
            level_now[2] = cmd.blue;
         end
         ACT_POWER: begin
            lamp_on = cmd.flag;
         end
         ACT_RESET_TIMERS: begin
            restart_timers();
         end
         default: begin
            for (int c = 0; c < NUM_CH; c++) begin
               dir_now[c] = cmd.flag ? DIR_UP : DIR_DOWN;
            end
            fade_on = 1'b1;
            auto_on = 1'b1;
            restart_timers();
         end
      endcase
      word.red = level_now[0];
      word.green = level_now[1];
      word.blue = level_now[2];
      word.lamp_on = lamp_on;
      word.auto_on = auto_on;
      word.fade_on = fade_on;
      return word;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void queue_cmd(action_type a, logic [7:0] r, logic [7:0] g,
                                     logic [7:0] b, logic f);
      led_cmd_type cmd;
      cmd.action = a;
      cmd.red = r;
      cmd.green = g;
      cmd.blue = b;
      cmd.flag = f;
      cmd_pending.push_back(cmd);
   endfunction

   // Command with random payload; fields that the command ignores vary too.
   function automatic void queue_rand(action_type a);
      queue_cmd(a, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
   endfunction

   // Driver: issues queued commands and predicts each one on its transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            status_due.push_back(apply_command(req_item));
            cmds_sent++;
            if (req_item.action == ACT_TICK) ticks_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_hold > 0) begin
               send_hold--;
               req_valid <= 1'b0;
            end else if (cmd_pending.size() > 0) begin
               req_item = cmd_pending.pop_front();
               req_action <= req_item.action;
               req_red_value <= req_item.red;
               req_green_value <= req_item.green;
               req_blue_value <= req_item.blue;
               req_flag <= req_item.flag;
               req_valid <= 1'b1;
               if (idle_on && $urandom_range(0, 3) == 0) send_hold = $urandom_range(1, 6);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random back-pressure and field-by-field comparison of each status.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               $error("status transfer with no command outstanding");
               fail_count++;
            end else begin
               want_word = status_due.pop_front();
               check_field("level_red", want_word.red, rsp_level_red);
               check_field("level_green", want_word.green, rsp_level_green);
               check_field("level_blue", want_word.blue, rsp_level_blue);
               check_field("lamp_on", want_word.lamp_on, rsp_lamp_on);
               check_field("auto_mode", want_word.auto_on, rsp_auto_mode);
               check_field("fading_active", want_word.fade_on, rsp_fading_active);
               words_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Register write; the block is idle, so the shadow copy follows at once.
   task automatic write_csr(csr_idx_type idx, logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_UPPER: upper_cfg = data[CFG_BITS-1:0];
         CSR_LOWER: lower_cfg = data[CFG_BITS-1:0];
         CSR_SPEED: speed_cfg = data[CFG_BITS-1:0];
         default: begin
            period_cfg = data[PER_BITS-1:0];
            restart_timers();
         end
      endcase
   endtask

   // Writes all four registers; unused high bits of the narrow ones carry junk.
   task automatic load_settings(logic [23:0] up, logic [23:0] lo, logic [23:0] sp,
                                logic [47:0] per);
      write_csr(CSR_UPPER, {24'($urandom), up});
      write_csr(CSR_LOWER, {24'($urandom), lo});
      write_csr(CSR_SPEED, {24'($urandom), sp});
      write_csr(CSR_PERIODS, per);
      settings_used++;
   endtask

   // Waits until every command has been sent and every status has come back.
   task automatic wait_drained();
      do @(negedge clock);
      while (cmd_pending.size() != 0 || req_valid || status_due.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // Random phase: mostly runs of ticks between commands, plus some noise.
   task automatic queue_random_phase(int n);
      int made;
      int k;
      int burst;
      made = 0;
      while (made < n) begin
         k = $urandom_range(0, 19);
         if (k < 9) begin
            burst = $urandom_range(2, 16);
            if (burst > n - made) burst = n - made;
            repeat (burst) queue_rand(ACT_TICK);
            made += burst;
         end else begin
            if (k < 11) queue_rand(ACT_START_AUTO);
            else if (k == 11) queue_rand(ACT_FADE);
            else if (k == 12) queue_rand(ACT_SET_LEVELS);
            else if (k < 15) queue_rand(ACT_POWER);
            else if (k == 15) queue_rand(ACT_RESET_TIMERS);
            else if (k == 16) queue_rand(ACT_GET);
            else if (k == 17) queue_rand(ACT_MANUAL_OFF);
            else queue_rand(action_type'($urandom_range(0, 7)));
            made++;
         end
      end
   endtask

   // Random ordered bounds, with now and then a lower bound above the upper one.
   task automatic load_random_settings(bit slow_red);
      logic [23:0] up;
      logic [23:0] lo;
      logic [23:0] sp;
      logic [47:0] per;
      logic [7:0]  a;
      logic [7:0]  b;
      for (int c = 0; c < NUM_CH; c++) begin
         a = 8'($urandom_range(0, 120));
         b = 8'($urandom_range(130, 255));
         if ($urandom_range(0, 5) == 0) begin
            up[8*c +: 8] = a;
            lo[8*c +: 8] = b;
         end else begin
            up[8*c +: 8] = b;
            lo[8*c +: 8] = a;
         end
         sp[8*c +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
         per[16*c +: 16] = 16'($urandom_range(0, 5));
      end
      if (slow_red) per[15:0] = 16'hFFFF;
      load_settings(up, lo, sp, per);
   endtask

   // Stimulus and end of run.
   initial begin
      upper_cfg = {NUM_CH{UPPER_RST_FIELD}};
      lower_cfg = {NUM_CH{LOWER_RST_FIELD}};
      speed_cfg = {NUM_CH{SPEED_RST_FIELD}};
      period_cfg = {NUM_CH{PERIOD_RST_FIELD}};
      for (int c = 0; c < NUM_CH; c++) begin
         level_now[c] = '0;
         dir_now[c] = DIR_UP;
      end
      restart_timers();
      auto_on = 1'b0;
      lamp_on = 1'b0;
      fade_on = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed commands under the reset settings.
      queue_cmd(ACT_GET, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_cmd(ACT_POWER, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      queue_cmd(ACT_SET_LEVELS, 8'hFF, 8'h00, 8'hA5, 1'b0);
      queue_cmd(ACT_MANUAL_OFF, 8'h00, 8'h00, 8'h00, 1'b1);
      queue_cmd(ACT_START_AUTO, 8'h00, 8'h80, 8'hFF, 1'b0);
      queue_cmd(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_cmd(ACT_RESET_TIMERS, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_cmd(ACT_POWER, 8'h00, 8'h00, 8'h00, 1'b0);
      wait_drained();

      // Red has its lower bound above the upper one, green a zero speed,
      // red and blue a zero period.
      load_settings(24'hC8_FF_0A, 24'h32_00_14, 24'hFF_00_07, 48'h0000_0001_0000);
      queue_cmd(ACT_START_AUTO, 8'hFF, 8'hFF, 8'h00, 1'b1);
      repeat (3) queue_cmd(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_cmd(ACT_FADE, 8'h00, 8'h00, 8'h00, 1'b1);
      repeat (3) queue_cmd(ACT_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      queue_cmd(ACT_FADE, 8'h00, 8'h00, 8'h00, 1'b0);
      repeat (2) queue_cmd(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_cmd(ACT_SET_LEVELS, 8'h00, 8'hFF, 8'h80, 1'b0);
      queue_cmd(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_cmd(ACT_MANUAL_OFF, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_cmd(ACT_GET, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      wait_drained();

      // Random phases; each one drains before the registers change.
      for (int phase = 0; phase < 7; phase++) begin
         if (phase == 0) begin
            load_settings(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 48'h0);
         end else if (phase == 1) begin
            load_settings(24'h000000, 24'hFFFFFF, 24'($urandom), 48'h0000_0003_0001);
         end else begin
            load_random_settings(phase == 2);
         end
         if (phase == 6) idle_on = 1'b0;
         queue_random_phase(89);
         wait_drained();
      end

      $display("Covered %0d commands (%0d ticks) under %0d register settings.",
               cmds_sent, ticks_sent, settings_used);
      $display("Compared %0d status words against the shadow model.", words_checked);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/rbl_pkg.sv
design/rbl_step_unit.sv
design/rbl_controller.sv
design/rbl_datapath.sv
design/rgb_breathing_led_controller_unit.sv
tb/sv/testbench.sv
